// ----- rtl/radix2_fft_dif_macros.svh -----
// Assertion macros shared by the FFT block.
`ifndef RADIX2_FFT_DIF_MACROS_SVH
`define RADIX2_FFT_DIF_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising clock edge outside reset.
`define RFD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, checked on every rising clock edge outside reset.
`define RFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define RFD_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define RFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ----- rtl/rfd_pkg.sv -----
// Shared types and constants of the radix-2 DIF FFT block.
package rfd_pkg;

   localparam int POINTS_DEF       = 1024;
   localparam int TWIDDLE_BITS_DEF = 16;

   localparam int SAMPLE_W    = 16;
   localparam int BIN_W       = 28;
   localparam int BIN_INDEX_W = 10;
   localparam int HALF_W      = 32;
   localparam int ENTRY_W     = 2 * HALF_W;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 32;

   // Register addresses.
   localparam logic [CSR_ADDR_W-1:0] REG_INVERSE_MODE = 2'd0;

   // Request operation codes.
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef struct packed {
      logic                       op;
      logic signed [SAMPLE_W-1:0] sample_real;
      logic signed [SAMPLE_W-1:0] sample_imag;
   } rfd_req_type;

   typedef struct packed {
      logic signed [BIN_W-1:0] bin_real;
      logic signed [BIN_W-1:0] bin_imag;
      logic [BIN_INDEX_W-1:0]  bin_index;
      logic                    last_bin;
   } rfd_rsp_type;

   // Frame store access strobes.
   typedef struct packed {
      logic rd;
      logic wr;
   } rfd_mem_ctl_type;

endpackage

// ----- rtl/radix2_fft_dif.sv -----
// Radix-2 decimation-in-frequency FFT with frame store and inverse mode.
//
// Requests carry op: a load writes the next sample of the frame, a read
// returns the next bin in natural order with its index and a last-bin mark.
// The load that fills the final position starts the transform; no request is
// taken until it has finished. Reads give one response each, no load does.
// A read is registered in the store and then in the response register; no
// request is taken while it is pending, and the next one is taken once the
// response is shown. The transform runs POINTS/2*log2(POINTS) butterflies,
// each bound by the single shared multiplier that forms its four products in
// turn, then a bit-reversal and scaling pass that reads each entry with its
// partner and writes both once, bound by the one store write port.
// After reset the store is cleared to zero, during which requests are
// stalled; configuration writes are taken at all times.
// While the receiver stalls, the pending response holds and no further
// request is taken.
`include "radix2_fft_dif_macros.svh"
module radix2_fft_dif import rfd_pkg::*; #(
   parameter int POINTS       = POINTS_DEF,
   parameter int TWIDDLE_BITS = TWIDDLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rfd_req_type           req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rfd_rsp_type           rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int AW = $clog2(POINTS);
   localparam int HW = AW - 1;

   logic                  inverse_ff;
   logic [AW-1:0]         load_pos_ff, read_pos_ff, rd_idx_ff;
   logic                  rd_pend_ff, rsp_valid_ff;
   rfd_rsp_type           rsp_data_ff;

   logic                  accept_w, host_wr_w, host_rd_w, start_w, busy_w;
   rfd_mem_ctl_type       eng_ctl_w, mem_ctl_w;
   logic [AW-1:0]         eng_ra_w, eng_rb_w, eng_wa_w, ra_w, wa_w;
   logic [ENTRY_W-1:0]    eng_wd_w, wd_w, qa_w, qb_w;
   logic [HW-1:0]         tw_addr_w;
   logic signed [TWIDDLE_BITS-1:0] tw_cos_w, tw_sin_w;

   // Configuration register.
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_INVERSE_MODE) ? CSR_DATA_W'(inverse_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         inverse_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   (csr_paddr == REG_INVERSE_MODE)) begin
         inverse_ff <= csr_pwdata[0];
      end
   end

   // Request handshake.
   assign req_stall = busy_w || rd_pend_ff || (rsp_valid_ff && rsp_stall);
   assign accept_w  = req_valid && !req_stall;
   assign host_wr_w = accept_w && (req_data.op == OP_LOAD);
   assign host_rd_w = accept_w && (req_data.op == OP_READ);
   assign start_w   = host_wr_w && (load_pos_ff == '1);

   // Frame counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         load_pos_ff <= '0;
         read_pos_ff <= '0;
         rd_pend_ff  <= 1'b0;
      end else begin
         rd_pend_ff <= host_rd_w;
         if (host_wr_w) load_pos_ff <= load_pos_ff + AW'(1);
         if (start_w) begin
            read_pos_ff <= '0;
         end else if (host_rd_w) begin
            read_pos_ff <= read_pos_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (host_rd_w) rd_idx_ff <= read_pos_ff;
   end

   // Store port sharing: the sequencer owns the store while it runs.
   always_comb begin
      if (busy_w) begin
         mem_ctl_w = eng_ctl_w;
         ra_w      = eng_ra_w;
         wa_w      = eng_wa_w;
         wd_w      = eng_wd_w;
      end else begin
         mem_ctl_w.rd = host_rd_w;
         mem_ctl_w.wr = host_wr_w;
         ra_w         = read_pos_ff;
         wa_w         = load_pos_ff;
         wd_w         = {HALF_W'(req_data.sample_real), HALF_W'(req_data.sample_imag)};
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rd_pend_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_pend_ff) begin
         rsp_data_ff.bin_real  <= qa_w[HALF_W+BIN_W-1:HALF_W];
         rsp_data_ff.bin_imag  <= qa_w[BIN_W-1:0];
         rsp_data_ff.bin_index <= BIN_INDEX_W'(rd_idx_ff);
         rsp_data_ff.last_bin  <= (rd_idx_ff == '1);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   rfd_store #(.POINTS(POINTS)) u_store (
      .clock     (clock),
      .ctl       (mem_ctl_w),
      .rd_addr_a (ra_w),
      .rd_addr_b (eng_rb_w),
      .wr_addr   (wa_w),
      .wr_data   (wd_w),
      .rd_data_a (qa_w),
      .rd_data_b (qb_w)
   );

   rfd_twiddle #(.POINTS(POINTS), .TWIDDLE_BITS(TWIDDLE_BITS)) u_twiddle (
      .clock  (clock),
      .addr   (tw_addr_w),
      .tw_cos (tw_cos_w),
      .tw_sin (tw_sin_w)
   );

   rfd_engine #(.POINTS(POINTS), .TWIDDLE_BITS(TWIDDLE_BITS)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (start_w),
      .inverse   (inverse_ff),
      .busy      (busy_w),
      .mem_ctl   (eng_ctl_w),
      .rd_addr_a (eng_ra_w),
      .rd_addr_b (eng_rb_w),
      .wr_addr   (eng_wa_w),
      .wr_data   (eng_wd_w),
      .rd_data_a (qa_w),
      .rd_data_b (qb_w),
      .tw_addr   (tw_addr_w),
      .tw_cos    (tw_cos_w),
      .tw_sin    (tw_sin_w)
   );

   // A pending read becomes a response in the next cycle.
   `RFD_ASSERT_NEXT(a_read_answered, clock, reset, rd_pend_ff, rsp_valid, "read not answered")
   // A response only appears after a read request.
   `RFD_ASSERT_IMPL(a_rsp_from_read, clock, reset, $rose(rsp_valid_ff), $past(rd_pend_ff), "response without read")
   // The final load of a frame starts the transform.
   `RFD_ASSERT_NEXT(a_start_busy, clock, reset, start_w, busy_w, "transform did not start")

endmodule

// ----- rtl/rfd_store.sv -----
// Frame store: one write port and two registered read ports.
module rfd_store import rfd_pkg::*; #(
   parameter int POINTS = POINTS_DEF
) (
   input  logic                      clock,
   input  rfd_mem_ctl_type           ctl,
   input  logic [$clog2(POINTS)-1:0] rd_addr_a,
   input  logic [$clog2(POINTS)-1:0] rd_addr_b,
   input  logic [$clog2(POINTS)-1:0] wr_addr,
   input  logic [ENTRY_W-1:0]        wr_data,
   output logic [ENTRY_W-1:0]        rd_data_a,
   output logic [ENTRY_W-1:0]        rd_data_b
);

   logic [ENTRY_W-1:0] mem [POINTS];

   // Write port.
   always_ff @(posedge clock) begin
      if (ctl.wr) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read ports; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (ctl.rd) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

// ----- rtl/rfd_twiddle.sv -----
// Twiddle table: cosine and sine of the forward kernel, registered read.
module rfd_twiddle import rfd_pkg::*; #(
   parameter int POINTS       = POINTS_DEF,
   parameter int TWIDDLE_BITS = TWIDDLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic [$clog2(POINTS)-2:0]         addr,
   output logic signed [TWIDDLE_BITS-1:0]    tw_cos,
   output logic signed [TWIDDLE_BITS-1:0]    tw_sin
);

   localparam int HALF = POINTS / 2;
   localparam int AW   = $clog2(POINTS);
   localparam int TF   = TWIDDLE_BITS - 2;
   localparam longint unsigned PI_Q30   = 64'd3373259426;
   localparam longint unsigned Q30_ONE  = 64'd1073741824;
   localparam longint unsigned Q30_HALF = 64'd536870912;

   // Restoring division by shift, compare and subtract.
   function automatic longint unsigned udiv(input longint unsigned n,
                                            input longint unsigned d);
      longint unsigned q;
      longint unsigned r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], n[i]};
         if (r >= d) begin
            r    = r - d;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // Alternating Taylor series in Q30.
   function automatic longint series(input longint unsigned start,
                                     input longint unsigned x2,
                                     input int first_div);
      longint          sum;
      longint unsigned t;
      longint unsigned d;
      sum = longint'(start);
      t   = start;
      for (int i = 1; i <= 10; i++) begin
         d = longint'(2 * i + first_div - 1) * longint'(2 * i + first_div);
         t = (t * x2 + Q30_HALF) >> 30;
         t = udiv(t, d);
         if (i[0]) sum = sum - longint'(t);
         else      sum = sum + longint'(t);
      end
      return sum;
   endfunction

   // Round a Q30 value to the twiddle format and clamp to plus or minus one.
   function automatic longint to_tw(input longint q);
      longint v;
      longint one;
      v   = (q + (longint'(1) <<< (29 - TF))) >>> (30 - TF);
      one = longint'(1) <<< TF;
      if (v > one)  v = one;
      if (v < -one) v = -one;
      return v;
   endfunction

   function automatic logic [2*TWIDDLE_BITS-1:0] tw_entry(input int j);
      logic            mirror;
      longint unsigned kk;
      longint unsigned x;
      longint unsigned x2;
      longint          c;
      longint          s;
      mirror = (4 * j) > POINTS;
      kk     = mirror ? longint'(HALF - j) : longint'(j);
      x      = (2 * kk * PI_Q30 + longint'(HALF)) >> AW;
      x2     = (x * x + Q30_HALF) >> 30;
      c      = to_tw(series(Q30_ONE, x2, 0));
      s      = to_tw(series(x, x2, 1));
      if (mirror) c = -c;
      return {c[TWIDDLE_BITS-1:0], s[TWIDDLE_BITS-1:0]};
   endfunction

   logic [2*TWIDDLE_BITS-1:0] rom_w [HALF];

   // Constant table, worked out at elaboration.
   for (genvar g = 0; g < HALF; g++) begin : g_rom
      localparam logic [2*TWIDDLE_BITS-1:0] ENT = tw_entry(g);
      assign rom_w[g] = ENT;
   end

   // Registered read.
   always_ff @(posedge clock) begin
      tw_cos <= rom_w[addr][2*TWIDDLE_BITS-1:TWIDDLE_BITS];
      tw_sin <= rom_w[addr][TWIDDLE_BITS-1:0];
   end

endmodule

// ----- rtl/rfd_engine.sv -----
// Transform sequencer: store clearing, DIF butterflies and bit-reversal reorder.
module rfd_engine import rfd_pkg::*; #(
   parameter int POINTS       = POINTS_DEF,
   parameter int TWIDDLE_BITS = TWIDDLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              inverse,
   output logic                              busy,
   output rfd_mem_ctl_type                   mem_ctl,
   output logic [$clog2(POINTS)-1:0]         rd_addr_a,
   output logic [$clog2(POINTS)-1:0]         rd_addr_b,
   output logic [$clog2(POINTS)-1:0]         wr_addr,
   output logic [ENTRY_W-1:0]                wr_data,
   input  logic [ENTRY_W-1:0]                rd_data_a,
   input  logic [ENTRY_W-1:0]                rd_data_b,
   output logic [$clog2(POINTS)-2:0]         tw_addr,
   input  logic signed [TWIDDLE_BITS-1:0]    tw_cos,
   input  logic signed [TWIDDLE_BITS-1:0]    tw_sin
);

   localparam int AW    = $clog2(POINTS);
   localparam int HW    = AW - 1;
   localparam int SW    = $clog2(AW);
   localparam int TF    = TWIDDLE_BITS - 2;
   localparam int P_W   = HALF_W + TWIDDLE_BITS;
   localparam int ACC_W = P_W + 2;
   localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (TF - 1);
   localparam logic [AW-1:0] HALF_PT = AW'(POINTS / 2);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_BF_RD, ST_BF_SUM, ST_M0, ST_M1, ST_M2, ST_M3, ST_M4,
      ST_BF_WB, ST_RV_RD, ST_RV_WA, ST_RV_WB
   } state_type;

   state_type                 state_ff;
   logic [SW-1:0]             stage_ff;
   logic [HW-1:0]             k_ff;
   logic [AW-1:0]             cnt_ff;
   logic signed [HALF_W-1:0]  dr_ff, di_ff, sum_re_ff, sum_im_ff, reb_ff;
   logic signed [P_W-1:0]     p_ff;
   logic signed [ACC_W-1:0]   acc_ff;

   logic [AW-1:0]             half_w, mask_w, kx_w, a_w, b_w, rev_w;
   logic signed [HALF_W-1:0]  mul_a_w;
   logic signed [TWIDDLE_BITS-1:0] mul_b_w;
   logic signed [P_W-1:0]     prod_w;
   logic signed [HALF_W:0]    re_a_w, im_a_w, re_b_w, im_b_w;
   logic signed [HALF_W-1:0]  imb_res_w;

   function automatic logic signed [HALF_W-1:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647)       return 32'sh7fffffff;
      else if (v < -64'sd2147483648) return 32'sh80000000;
      else                           return v[HALF_W-1:0];
   endfunction

   function automatic logic signed [HALF_W-1:0] sat28(input logic signed [HALF_W:0] v);
      if (v > 33'sd134217727)       return 32'sd134217727;
      else if (v < -33'sd134217728) return -32'sd134217728;
      else                          return v[HALF_W-1:0];
   endfunction

   // Final scaling of one entry: inverse conjugation and shift where asked, then saturation.
   function automatic logic [ENTRY_W-1:0] finish(input logic [ENTRY_W-1:0] e,
                                                input logic inv);
      logic signed [HALF_W:0] re;
      logic signed [HALF_W:0] im;
      re = HALF_W'(signed'(e[ENTRY_W-1:HALF_W]));
      im = HALF_W'(signed'(e[HALF_W-1:0]));
      re = {re[HALF_W-1], re[HALF_W-1:0]};
      im = {im[HALF_W-1], im[HALF_W-1:0]};
      if (inv) begin
         re = re >>> AW;
         im = (-im) >>> AW;
      end
      return {sat28(re), sat28(im)};
   endfunction

   // Butterfly addressing: a zero bit inserted at the stage's bit position.
   always_comb begin
      half_w = HALF_PT >> stage_ff;
      mask_w = half_w - AW'(1);
      kx_w   = {1'b0, k_ff};
      a_w    = ((kx_w & ~mask_w) << 1) | (kx_w & mask_w);
      b_w    = a_w | half_w;
      for (int i = 0; i < AW; i++) begin
         rev_w[i] = cnt_ff[AW-1-i];
      end
   end

   assign tw_addr = HW'((kx_w & mask_w) << stage_ff);

   // Operands of the butterfly, conjugated on the first stage of an inverse.
   always_comb begin
      re_a_w = {rd_data_a[ENTRY_W-1], rd_data_a[ENTRY_W-1:HALF_W]};
      im_a_w = {rd_data_a[HALF_W-1], rd_data_a[HALF_W-1:0]};
      re_b_w = {rd_data_b[ENTRY_W-1], rd_data_b[ENTRY_W-1:HALF_W]};
      im_b_w = {rd_data_b[HALF_W-1], rd_data_b[HALF_W-1:0]};
      if (inverse && (stage_ff == '0)) begin
         im_a_w = -im_a_w;
         im_b_w = -im_b_w;
      end
   end

   // One shared multiplier, four products per butterfly.
   always_comb begin
      case (state_ff)
         ST_M1:   begin mul_a_w = di_ff; mul_b_w = tw_sin; end
         ST_M2:   begin mul_a_w = di_ff; mul_b_w = tw_cos; end
         ST_M3:   begin mul_a_w = dr_ff; mul_b_w = tw_sin; end
         default: begin mul_a_w = dr_ff; mul_b_w = tw_cos; end
      endcase
      prod_w = mul_a_w * mul_b_w;
   end

   assign imb_res_w = sat32(64'(acc_ff >>> TF));

   // Store accesses for each step.
   always_comb begin
      mem_ctl   = '0;
      rd_addr_a = a_w;
      rd_addr_b = b_w;
      wr_addr   = a_w;
      wr_data   = {sum_re_ff, sum_im_ff};
      case (state_ff)
         ST_CLEAR: begin
            mem_ctl.wr = 1'b1;
            wr_addr    = cnt_ff;
            wr_data    = '0;
         end
         ST_BF_RD: mem_ctl.rd = 1'b1;
         ST_M0:    mem_ctl.wr = 1'b1;
         ST_BF_WB: begin
            mem_ctl.wr = 1'b1;
            wr_addr    = b_w;
            wr_data    = {reb_ff, imb_res_w};
         end
         ST_RV_RD: begin
            mem_ctl.rd = 1'b1;
            rd_addr_a  = cnt_ff;
            rd_addr_b  = rev_w;
         end
         ST_RV_WA: begin
            mem_ctl.wr = (rev_w >= cnt_ff);
            wr_addr    = cnt_ff;
            wr_data    = (rev_w > cnt_ff) ? finish(rd_data_b, inverse)
                                          : finish(rd_data_a, inverse);
         end
         ST_RV_WB: begin
            mem_ctl.wr = 1'b1;
            wr_addr    = rev_w;
            wr_data    = finish(rd_data_a, inverse);
         end
         default: ;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   // Sequencer state and butterfly datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
         stage_ff <= '0;
         k_ff     <= '0;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               cnt_ff <= cnt_ff + AW'(1);
               if (cnt_ff == '1) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               stage_ff <= '0;
               k_ff     <= '0;
               if (start) state_ff <= ST_BF_RD;
            end
            ST_BF_RD: state_ff <= ST_BF_SUM;
            ST_BF_SUM: begin
               sum_re_ff <= sat32(64'(re_a_w + re_b_w));
               sum_im_ff <= sat32(64'(im_a_w + im_b_w));
               dr_ff     <= sat32(64'(re_a_w - re_b_w));
               di_ff     <= sat32(64'(im_a_w - im_b_w));
               state_ff  <= ST_M0;
            end
            ST_M0: begin
               p_ff     <= prod_w;
               state_ff <= ST_M1;
            end
            ST_M1: begin
               acc_ff   <= ACC_W'(p_ff) + RND;
               p_ff     <= prod_w;
               state_ff <= ST_M2;
            end
            ST_M2: begin
               acc_ff   <= acc_ff + ACC_W'(p_ff);
               p_ff     <= prod_w;
               state_ff <= ST_M3;
            end
            ST_M3: begin
               reb_ff   <= imb_res_w;
               acc_ff   <= ACC_W'(p_ff) + RND;
               p_ff     <= prod_w;
               state_ff <= ST_M4;
            end
            ST_M4: begin
               acc_ff   <= acc_ff - ACC_W'(p_ff);
               state_ff <= ST_BF_WB;
            end
            ST_BF_WB: begin
               k_ff <= k_ff + HW'(1);
               if (k_ff == '1) begin
                  if (stage_ff == SW'(AW - 1)) begin
                     cnt_ff   <= '0;
                     state_ff <= ST_RV_RD;
                  end else begin
                     stage_ff <= stage_ff + SW'(1);
                     state_ff <= ST_BF_RD;
                  end
               end else begin
                  state_ff <= ST_BF_RD;
               end
            end
            ST_RV_RD: state_ff <= ST_RV_WA;
            ST_RV_WA: begin
               if (rev_w > cnt_ff) begin
                  state_ff <= ST_RV_WB;
               end else begin
                  cnt_ff   <= cnt_ff + AW'(1);
                  state_ff <= (cnt_ff == '1) ? ST_IDLE : ST_RV_RD;
               end
            end
            ST_RV_WB: begin
               cnt_ff   <= cnt_ff + AW'(1);
               state_ff <= (cnt_ff == '1) ? ST_IDLE : ST_RV_RD;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ----- test/radix2_fft_dif_checker.sv -----
// Checker for the radix-2 DIF FFT block: predicts every bin and compares responses.
`timescale 1ns / 100ps
module radix2_fft_dif_checker import rfd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  rfd_req_type           req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rfd_rsp_type           rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output int                    fail_count,
   output int                    bins_pending
);

   localparam int FRAME = POINTS_DEF;
   localparam int LOG_FRAME = $clog2(POINTS_DEF);
   localparam int FRAC = TWIDDLE_BITS_DEF - 2;
   localparam longint unsigned PI_Q30 = 64'd3373259426;
   localparam longint unsigned ONE_Q30 = 64'd1073741824;

   longint store_re [FRAME];
   longint store_im [FRAME];
   longint cos_tab [FRAME/2];
   longint sin_tab [FRAME/2];
   int unsigned load_pos;
   int unsigned read_pos;
   bit inverse_on;
   rfd_rsp_type bins_due [$];

   initial begin
      fail_count = 0;
      bins_pending = 0;
   end

   function automatic longint clamp(longint v, int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      return (v > hi) ? hi : ((v < lo) ? lo : v);
   endfunction

   // Eleven-term Taylor series in Q30, each term rounded then divided with truncation.
   function automatic longint taylor(longint unsigned start, longint unsigned x2, int fd);
      longint sum;
      longint unsigned t;
      longint unsigned d;
      sum = longint'(start);
      t = start;
      for (int i = 1; i <= 10; i++) begin
         d = longint'(2 * i + fd - 1) * longint'(2 * i + fd);
         t = (t * x2 + (ONE_Q30 >> 1)) >> 30;
         t = t / d;
         sum = (i % 2 == 1) ? sum - longint'(t) : sum + longint'(t);
      end
      return sum;
   endfunction

   function automatic longint twiddle_round(longint q30);
      longint v;
      v = (q30 + (longint'(1) <<< (30 - FRAC - 1))) >>> (30 - FRAC);
      if (v > (longint'(1) <<< FRAC)) v = longint'(1) <<< FRAC;
      if (v < -(longint'(1) <<< FRAC)) v = -(longint'(1) <<< FRAC);
      return v;
   endfunction

   // Twiddle table; the second quadrant is mirrored from the first.
   initial begin
      longint unsigned kk;
      longint unsigned x;
      longint unsigned x2;
      bit mirror;
      for (int j = 0; j < FRAME / 2; j++) begin
         mirror = (4 * j) > FRAME;
         kk = mirror ? longint'(FRAME / 2 - j) : longint'(j);
         x = (2 * kk * PI_Q30 + FRAME / 2) / FRAME;
         x2 = (x * x + (ONE_Q30 >> 1)) >> 30;
         cos_tab[j] = mirror ? -twiddle_round(taylor(ONE_Q30, x2, 0))
                             : twiddle_round(taylor(ONE_Q30, x2, 0));
         sin_tab[j] = twiddle_round(taylor(x, x2, 1));
      end
   end

   // In-place DIF transform, bit-reversal reorder, inverse scaling and final saturation.
   task automatic run_transform();
      longint c, s, dr, di, tmp;
      int unsigned b, rev;
      if (inverse_on)
         for (int a = 0; a < FRAME; a++) store_im[a] = -store_im[a];
      for (int half = FRAME / 2; half >= 1; half = half / 2) begin
         for (int l = 0; l < half; l++) begin
            c = cos_tab[(l * (FRAME / (2 * half))) % (FRAME / 2)];
            s = sin_tab[(l * (FRAME / (2 * half))) % (FRAME / 2)];
            for (int a = l; a + half < FRAME; a += 2 * half) begin
               b = a + half;
               dr = clamp(store_re[a] - store_re[b], 32);
               di = clamp(store_im[a] - store_im[b], 32);
               store_re[a] = clamp(store_re[a] + store_re[b], 32);
               store_im[a] = clamp(store_im[a] + store_im[b], 32);
               store_re[b] = clamp((dr * c + di * s + (longint'(1) <<< (FRAC - 1))) >>> FRAC, 32);
               store_im[b] = clamp((di * c - dr * s + (longint'(1) <<< (FRAC - 1))) >>> FRAC, 32);
            end
         end
      end
      for (int a = 0; a < FRAME; a++) begin
         rev = 0;
         for (int i = 0; i < LOG_FRAME; i++) rev = (rev << 1) | ((a >> i) & 1);
         if (rev > a) begin
            tmp = store_re[a]; store_re[a] = store_re[rev]; store_re[rev] = tmp;
            tmp = store_im[a]; store_im[a] = store_im[rev]; store_im[rev] = tmp;
         end
      end
      for (int a = 0; a < FRAME; a++) begin
         if (inverse_on) begin
            store_im[a] = (-store_im[a]) >>> LOG_FRAME;
            store_re[a] = store_re[a] >>> LOG_FRAME;
         end
         store_re[a] = clamp(store_re[a], BIN_W);
         store_im[a] = clamp(store_im[a], BIN_W);
      end
   endtask

   always @(posedge clock) begin
      rfd_rsp_type want;
      if (reset) begin
         for (int a = 0; a < FRAME; a++) begin
            store_re[a] = 0;
            store_im[a] = 0;
         end
         load_pos = 0;
         read_pos = 0;
         inverse_on = 0;
         bins_due.delete();
      end else begin
         // Register writes.
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == REG_INVERSE_MODE)
            inverse_on = csr_pwdata[0];

         // Accepted requests.
         if (req_valid && !req_stall) begin
            if (req_data.op == OP_LOAD) begin
               store_re[load_pos] = longint'(req_data.sample_real);
               store_im[load_pos] = longint'(req_data.sample_imag);
               load_pos++;
               if (load_pos >= FRAME) begin
                  run_transform();
                  load_pos = 0;
                  read_pos = 0;
               end
            end else begin
               want.bin_real = store_re[read_pos][BIN_W-1:0];
               want.bin_imag = store_im[read_pos][BIN_W-1:0];
               want.bin_index = read_pos[BIN_INDEX_W-1:0];
               want.last_bin = (read_pos == FRAME - 1);
               bins_due.push_back(want);
               read_pos = (read_pos + 1) % FRAME;
            end
         end

         // Accepted responses.
         if (rsp_valid && !rsp_stall) begin
            if (bins_due.size() == 0) begin
               $error("Response arrived with no read outstanding.");
               fail_count++;
            end else begin
               want = bins_due.pop_front();
               if (rsp_data.bin_real !== want.bin_real) begin
                  $error("bin_real: expected %0d, got %0d", want.bin_real, rsp_data.bin_real);
                  fail_count++;
               end
               if (rsp_data.bin_imag !== want.bin_imag) begin
                  $error("bin_imag: expected %0d, got %0d", want.bin_imag, rsp_data.bin_imag);
                  fail_count++;
               end
               if (rsp_data.bin_index !== want.bin_index) begin
                  $error("bin_index: expected %0d, got %0d", want.bin_index,
                         rsp_data.bin_index);
                  fail_count++;
               end
               if (rsp_data.last_bin !== want.last_bin) begin
                  $error("last_bin: expected %0d, got %0d", want.last_bin, rsp_data.last_bin);
                  fail_count++;
               end
            end
         end
      end
      bins_pending = bins_due.size();
   end

endmodule

// ----- test/radix2_fft_dif_tb.sv -----
// Top of the FFT testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps
module radix2_fft_dif_tb;
   import rfd_pkg::*;

   localparam int FRAME = POINTS_DEF;
   localparam int CYCLE_LIMIT = 500000;
   localparam int SETTLE = 64;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   rfd_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   rfd_rsp_type rsp_data;
   logic csr_psel = 0;
   logic csr_penable = 0;
   logic csr_pwrite = 0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   int fail_count;
   int bins_pending;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int unsigned frame_fill = 0;
   int unsigned fill_goal = 0;
   int cycles = 0;
   int hold_left = 0;
   bit hold_toggle = 0;
   bit hold_seen = 0;

   radix2_fft_dif uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   radix2_fft_dif_checker bin_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_pready(csr_pready), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .fail_count(fail_count), .bins_pending(bins_pending)
   );

   always #5 clock = ~clock;

   // Watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Receiver: random stalls, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1;
         hold_left <= hold_left - 1;
      end else if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= 400;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // One request; the sender may idle first, and the payload holds while stalled.
   task automatic send_request(input logic op, input logic [15:0] re, input logic [15:0] im);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data.op <= op;
      req_data.sample_real <= re;
      req_data.sample_imag <= im;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == OP_LOAD) frame_fill = (frame_fill + 1) % FRAME;
   endtask

   task automatic write_inverse(input bit value);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= REG_INVERSE_MODE;
      csr_pwdata <= {31'd0, value};
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
   endtask

   // Wait for the block to drain, then let it settle before the next setting.
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (bins_pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(9))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'($urandom_range(0, 15)) - 16'd8;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      write_inverse(0);

      // Directed: reads of the cleared store, extreme loads, then reads of raw samples.
      repeat (3) send_request(OP_READ, 16'h0, 16'h0);
      send_request(OP_LOAD, 16'h7fff, 16'h8000);
      send_request(OP_LOAD, 16'h8000, 16'h7fff);
      send_request(OP_LOAD, 16'h0000, 16'h0000);
      send_request(OP_LOAD, 16'hffff, 16'hffff);
      send_request(OP_LOAD, 16'h5555, 16'haaaa);
      send_request(OP_LOAD, 16'haaaa, 16'h5555);
      send_request(OP_LOAD, 16'h0001, 16'hfffe);
      send_request(OP_LOAD, 16'h7fff, 16'h7fff);
      repeat (4) send_request(OP_READ, 16'h0, 16'h0);
      drain();

      // Random phases, each loading a share of one frame; the last one completes it.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 6;  recv_idle_pct = 46; end
            1: begin send_idle_pct = 46; recv_idle_pct = 6;  end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         write_inverse(phase == 1);
         fill_goal = (phase == 2) ? 0 : (phase + 1) * (FRAME / 3);

         // A long receiver hold-off while requests keep coming.
         if (phase == 0) hold_toggle <= ~hold_toggle;

         // Load the share, with stray reads of the partly loaded store.
         do begin
            if ($urandom_range(99) < 5) send_request(OP_READ, 16'($urandom), 16'($urandom));
            else send_request(OP_LOAD, pick_sample(), pick_sample());
         end while (frame_fill != fill_goal);

         // Pause until every outstanding bin has come back.
         if (phase == 1) begin
            req_valid <= 0;
            @(posedge clock);
            while (bins_pending != 0) @(posedge clock);
         end

         // Read the first bins of the finished frame, with a few loads mixed in.
         if (phase == 2) begin
            for (int k = 0; k < 96; k++) begin
               if (k > 32 && $urandom_range(99) < 4)
                  send_request(OP_LOAD, pick_sample(), pick_sample());
               else
                  send_request(OP_READ, 16'($urandom), 16'($urandom));
            end
         end
         send_request(OP_READ, 16'h0, 16'h0);
         drain();
      end

      write_inverse(0);
      drain();
      if (fail_count == 0 && bins_pending == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ----- radix2_fft_dif.f -----
+incdir+rtl
rtl/rfd_pkg.sv
rtl/rfd_store.sv
rtl/rfd_twiddle.sv
rtl/rfd_engine.sv
rtl/radix2_fft_dif.sv
test/radix2_fft_dif_checker.sv
test/radix2_fft_dif_tb.sv
